/* hdl/triangle_circumcenter_3d_defines.svh */
// assertion helpers used by the rtl top level
`ifndef TRIANGLE_CIRCUMCENTER_3D_DEFINES_SVH
`define TRIANGLE_CIRCUMCENTER_3D_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TCC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define TCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tcc_pkg.sv */
package tcc_pkg;

  localparam int CoordW   = 16;
  localparam int OutW     = 32;
  localparam int DiffW    = CoordW + 1;
  localparam int NrmW     = 2 * DiffW + 1;
  localparam int RhsW     = 2 * DiffW + 2;
  localparam int Rhs2W    = NrmW + DiffW + 2;
  localparam int CrsW     = NrmW + DiffW + 1;
  localparam int DetW     = 2 * NrmW + 2;
  localparam int DenW     = DetW;
  localparam int NumW     = 5 * DiffW + 7;
  localparam int FrontLat = 10;
  localparam int DivSteps = OutW + 1;
  localparam int LaneLat  = DivSteps + 1;

  localparam logic [OutW-1:0] PosMax = 32'h7FFF_FFFF;
  localparam logic [OutW-1:0] NegMin = 32'h8000_0000;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] az;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by_coord;
    logic signed [CoordW-1:0] bz;
    logic signed [CoordW-1:0] cx_in;
    logic signed [CoordW-1:0] cy_in;
    logic signed [CoordW-1:0] cz_in;
  } in_t;

  typedef struct packed {
    logic signed [OutW-1:0] center_x;
    logic signed [OutW-1:0] center_y;
    logic signed [OutW-1:0] center_z;
    logic                   singular;
    logic                   saturated;
  } out_t;

  typedef struct packed {
    logic [OutW-1:0] val;
    logic            sat;
  } lane_res_t;

endpackage

/* hdl/triangle_circumcenter_3d.sv */
// throughput: one word per cycle while not stalled by out_stall, set by
// the fully pipelined multiply groups
// and the 33-stage restoring divider (one quotient bit per stage per lane)
// out_stall on a valid word freezes all stages; in_stall follows combinationally
// reset clears the valid bits only, the datapath is not reset
`include "triangle_circumcenter_3d_defines.svh"

module triangle_circumcenter_3d
  import tcc_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int PipeLat = FrontLat + LaneLat;

  logic en;
  logic [PipeLat-1:0] pipe_v_r;
  logic out_valid_r;
  out_t out_data_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  logic signed [NumW-1:0] f_num [3];
  logic [DenW-1:0]        f_den;
  logic                   f_sing;

  tcc_front u_front (
    .clk(clk), .en(en), .in_data(in_data),
    .num(f_num), .den(f_den), .sing(f_sing));

  lane_res_t lane_res [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    tcc_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk(clk), .en(en), .num(f_num[k]), .den(f_den), .res(lane_res[k]));
  end

  logic sing_d_r [LaneLat];

  always_ff @(posedge clk) begin
    if (en) begin
      sing_d_r[0] <= f_sing;
      for (int s = 1; s < LaneLat; s++) begin
        sing_d_r[s] <= sing_d_r[s-1];
      end
    end
  end

  logic sing_out;
  assign sing_out = sing_d_r[LaneLat-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_v_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      pipe_v_r    <= {pipe_v_r[PipeLat-2:0], in_valid};
      out_valid_r <= pipe_v_r[PipeLat-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.center_x  <= sing_out ? '0 : lane_res[0].val;
      out_data_r.center_y  <= sing_out ? '0 : lane_res[1].val;
      out_data_r.center_z  <= sing_out ? '0 : lane_res[2].val;
      out_data_r.singular  <= sing_out;
      out_data_r.saturated <= !sing_out &&
                              (lane_res[0].sat || lane_res[1].sat || lane_res[2].sat);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TCC_ASSERT_SAME(a_sing_zero, out_valid_r && out_data_r.singular, out_data_r.center_x == '0 && out_data_r.center_y == '0 && out_data_r.center_z == '0 && !out_data_r.saturated, "singular word not zeroed")
  `TCC_ASSERT_SAME(a_sat_limit, out_valid_r && out_data_r.saturated, out_data_r.center_x == PosMax || out_data_r.center_x == NegMin || out_data_r.center_y == PosMax || out_data_r.center_y == NegMin || out_data_r.center_z == PosMax || out_data_r.center_z == NegMin, "saturated word has no clipped coordinate")
  `TCC_ASSERT_NEXT(a_hold_pipe, !en, $stable(pipe_v_r), "pipeline moved while stalled")
  `TCC_ASSERT_NEXT(a_drain, en && pipe_v_r[PipeLat-1], out_valid_r, "word lost at output")

endmodule

/* hdl/tcc_mul.sv */
module tcc_mul #(
  parameter int AW = 17,
  parameter int BW = 17
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [AW-1:0]  a,
  input  logic signed [BW-1:0]  b,
  output logic signed [AW+BW-1:0] p
);

  localparam int LB = BW / 2;
  localparam int HB = BW - LB;
  localparam int PW = AW + BW;

  logic signed [AW+LB:0]   lo_r;
  logic signed [AW+HB-1:0] hi_r;
  logic signed [PW-1:0]    p_r;

  // split b into an unsigned low half and a signed high half
  always_ff @(posedge clk) begin
    if (en) begin
      lo_r <= a * $signed({1'b0, b[LB-1:0]});
      hi_r <= a * $signed(b[BW-1:LB]);
      p_r  <= $signed({hi_r, {LB{1'b0}}}) + PW'(lo_r);
    end
  end

  assign p = p_r;

endmodule

/* hdl/tcc_front.sv */
module tcc_front
  import tcc_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  in_t                    in_data,
  output logic signed [NumW-1:0] num [3],
  output logic [DenW-1:0]        den,
  output logic                   sing
);

  logic signed [CoordW-1:0] a [3];
  logic signed [CoordW-1:0] b [3];
  logic signed [CoordW-1:0] c [3];

  assign a[0] = in_data.ax;
  assign a[1] = in_data.ay;
  assign a[2] = in_data.az;
  assign b[0] = in_data.bx;
  assign b[1] = in_data.by_coord;
  assign b[2] = in_data.bz;
  assign c[0] = in_data.cx_in;
  assign c[1] = in_data.cy_in;
  assign c[2] = in_data.cz_in;

  // edge vectors and sums
  logic signed [DiffW-1:0] r0_r [3];
  logic signed [DiffW-1:0] r1_r [3];
  logic signed [DiffW-1:0] sac_r [3];
  logic signed [DiffW-1:0] sab_r [3];
  logic signed [DiffW-1:0] a2_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        r0_r[k]  <= DiffW'(c[k]) - DiffW'(a[k]);
        r1_r[k]  <= DiffW'(b[k]) - DiffW'(a[k]);
        sac_r[k] <= DiffW'(a[k]) + DiffW'(c[k]);
        sab_r[k] <= DiffW'(a[k]) + DiffW'(b[k]);
        a2_r[k]  <= DiffW'(a[k]) + DiffW'(a[k]);
      end
    end
  end

  // delays to the second multiply group
  logic signed [DiffW-1:0] r0_d_r [3][3];
  logic signed [DiffW-1:0] r1_d_r [3][3];
  logic signed [DiffW-1:0] a2_d_r [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      r0_d_r[0] <= r0_r;
      r1_d_r[0] <= r1_r;
      a2_d_r[0] <= a2_r;
      for (int s = 1; s < 3; s++) begin
        r0_d_r[s] <= r0_d_r[s-1];
        r1_d_r[s] <= r1_d_r[s-1];
        a2_d_r[s] <= a2_d_r[s-1];
      end
    end
  end

  // normal and first two right-hand sides
  logic signed [2*DiffW-1:0] na_p [3];
  logic signed [2*DiffW-1:0] nb_p [3];
  logic signed [2*DiffW-1:0] ra_p [3];
  logic signed [2*DiffW-1:0] rb_p [3];

  for (genvar k = 0; k < 3; k++) begin : g_grp_a
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;
    tcc_mul #(.AW(DiffW), .BW(DiffW)) u_na (
      .clk(clk), .en(en), .a(r0_r[K1]), .b(r1_r[K2]), .p(na_p[k]));
    tcc_mul #(.AW(DiffW), .BW(DiffW)) u_nb (
      .clk(clk), .en(en), .a(r1_r[K1]), .b(r0_r[K2]), .p(nb_p[k]));
    tcc_mul #(.AW(DiffW), .BW(DiffW)) u_ra (
      .clk(clk), .en(en), .a(r0_r[k]), .b(sac_r[k]), .p(ra_p[k]));
    tcc_mul #(.AW(DiffW), .BW(DiffW)) u_rb (
      .clk(clk), .en(en), .a(r1_r[k]), .b(sab_r[k]), .p(rb_p[k]));
  end

  logic signed [NrmW-1:0] n_r [3];
  logic signed [RhsW-1:0] rhs0_r;
  logic signed [RhsW-1:0] rhs1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        n_r[k] <= NrmW'(na_p[k]) - NrmW'(nb_p[k]);
      end
      rhs0_r <= RhsW'(ra_p[0]) + RhsW'(ra_p[1]) + RhsW'(ra_p[2]);
      rhs1_r <= RhsW'(rb_p[0]) + RhsW'(rb_p[1]) + RhsW'(rb_p[2]);
    end
  end

  logic signed [NrmW-1:0] n_d_r [3][3];
  logic signed [RhsW-1:0] rhs0_d_r [3];
  logic signed [RhsW-1:0] rhs1_d_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      n_d_r[0]    <= n_r;
      rhs0_d_r[0] <= rhs0_r;
      rhs1_d_r[0] <= rhs1_r;
      for (int s = 1; s < 3; s++) begin
        n_d_r[s]    <= n_d_r[s-1];
        rhs0_d_r[s] <= rhs0_d_r[s-1];
        rhs1_d_r[s] <= rhs1_d_r[s-1];
      end
    end
  end

  // adjugate columns, plane offset and determinant
  logic signed [DiffW+NrmW-1:0] ua_p [3];
  logic signed [DiffW+NrmW-1:0] ub_p [3];
  logic signed [DiffW+NrmW-1:0] va_p [3];
  logic signed [DiffW+NrmW-1:0] vb_p [3];
  logic signed [DiffW+NrmW-1:0] np_p [3];
  logic signed [2*NrmW-1:0]     sq_p [3];

  for (genvar k = 0; k < 3; k++) begin : g_grp_b
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;
    tcc_mul #(.AW(DiffW), .BW(NrmW)) u_ua (
      .clk(clk), .en(en), .a(r1_d_r[2][K1]), .b(n_r[K2]), .p(ua_p[k]));
    tcc_mul #(.AW(DiffW), .BW(NrmW)) u_ub (
      .clk(clk), .en(en), .a(r1_d_r[2][K2]), .b(n_r[K1]), .p(ub_p[k]));
    tcc_mul #(.AW(DiffW), .BW(NrmW)) u_va (
      .clk(clk), .en(en), .a(r0_d_r[2][K2]), .b(n_r[K1]), .p(va_p[k]));
    tcc_mul #(.AW(DiffW), .BW(NrmW)) u_vb (
      .clk(clk), .en(en), .a(r0_d_r[2][K1]), .b(n_r[K2]), .p(vb_p[k]));
    tcc_mul #(.AW(DiffW), .BW(NrmW)) u_np (
      .clk(clk), .en(en), .a(a2_d_r[2][k]), .b(n_r[k]), .p(np_p[k]));
    tcc_mul #(.AW(NrmW), .BW(NrmW)) u_sq (
      .clk(clk), .en(en), .a(n_r[k]), .b(n_r[k]), .p(sq_p[k]));
  end

  logic signed [CrsW-1:0]  u_r [3];
  logic signed [CrsW-1:0]  v_r [3];
  logic signed [Rhs2W-1:0] rhs2_r;
  logic signed [DetW-1:0]  det_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        u_r[k] <= CrsW'(ua_p[k]) - CrsW'(ub_p[k]);
        v_r[k] <= CrsW'(va_p[k]) - CrsW'(vb_p[k]);
      end
      rhs2_r <= Rhs2W'(np_p[0]) + Rhs2W'(np_p[1]) + Rhs2W'(np_p[2]);
      det_r  <= DetW'(sq_p[0]) + DetW'(sq_p[1]) + DetW'(sq_p[2]);
    end
  end

  logic signed [DetW-1:0] det_d_r [2];

  always_ff @(posedge clk) begin
    if (en) begin
      det_d_r[0] <= det_r;
      det_d_r[1] <= det_d_r[0];
    end
  end

  // cramer numerators
  logic signed [RhsW+CrsW-1:0]  t0_p [3];
  logic signed [RhsW+CrsW-1:0]  t1_p [3];
  logic signed [NrmW+Rhs2W-1:0] t2_p [3];

  for (genvar k = 0; k < 3; k++) begin : g_grp_c
    tcc_mul #(.AW(RhsW), .BW(CrsW)) u_t0 (
      .clk(clk), .en(en), .a(rhs0_d_r[2]), .b(u_r[k]), .p(t0_p[k]));
    tcc_mul #(.AW(RhsW), .BW(CrsW)) u_t1 (
      .clk(clk), .en(en), .a(rhs1_d_r[2]), .b(v_r[k]), .p(t1_p[k]));
    tcc_mul #(.AW(NrmW), .BW(Rhs2W)) u_t2 (
      .clk(clk), .en(en), .a(n_d_r[2][k]), .b(rhs2_r), .p(t2_p[k]));
  end

  logic signed [NumW-1:0] num_r [3];
  logic [DenW-1:0]        den_r;
  logic                   sing_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        num_r[k] <= NumW'(t0_p[k]) + NumW'(t1_p[k]) + NumW'(t2_p[k]);
      end
      den_r  <= {det_d_r[1][DetW-2:0], 1'b0};
      sing_r <= (det_d_r[1] == '0);
    end
  end

  assign num  = num_r;
  assign den  = den_r;
  assign sing = sing_r;

endmodule

/* hdl/tcc_div_lane.sv */
module tcc_div_lane
  import tcc_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [NumW-1:0] num,
  input  logic [DenW-1:0]        den,
  output lane_res_t              res
);

  localparam int MagW = NumW + FRAC_BITS;
  localparam int RemW = (MagW > DenW + OutW) ? MagW : DenW + OutW;

  logic [NumW-1:0] mag;
  assign mag = num[NumW-1] ? NumW'(-num) : num;

  logic [RemW-1:0] rem_r [DivSteps];
  logic [DenW-1:0] den_r [DivSteps];
  logic            neg_r [DivSteps+1];
  logic [OutW:0]   q_r   [DivSteps+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= RemW'(mag) << FRAC_BITS;
      den_r[0] <= den;
      neg_r[0] <= num[NumW-1];
      q_r[0]   <= '0;
    end
  end

  // one quotient bit a stage, top bit flags overflow
  for (genvar j = 1; j <= DivSteps; j++) begin : g_step
    localparam int Sh = OutW + 1 - j;
    logic [RemW:0] trial;
    assign trial = {1'b0, rem_r[j-1]} - {1'b0, (RemW'(den_r[j-1]) << Sh)};

    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[j] <= neg_r[j-1];
        q_r[j]   <= q_r[j-1] | ({{OutW{1'b0}}, !trial[RemW]} << Sh);
      end
    end

    if (j < DivSteps) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= trial[RemW] ? rem_r[j-1] : trial[RemW-1:0];
          den_r[j] <= den_r[j-1];
        end
      end
    end
  end

  logic [OutW:0] q;
  assign q = q_r[DivSteps];

  always_comb begin
    if (!neg_r[DivSteps]) begin
      res.sat = q[OutW] | q[OutW-1];
      res.val = res.sat ? PosMax : q[OutW-1:0];
    end else begin
      res.sat = q[OutW] | (q[OutW-1:0] > NegMin);
      res.val = res.sat ? NegMin : OutW'(-q[OutW-1:0]);
    end
  end

endmodule

/* verif/triangle_circumcenter_3d_tb.sv */
`timescale 1ns / 100ps

module triangle_circumcenter_3d_tb;
  import tcc_pkg::*;

  localparam int FracBits = 8;
  localparam int NumItems = 1350;

  typedef logic signed [255:0] wide_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  in_t  pending_tris[$];
  out_t expected_centers[$];
  int   errors = 0;
  int   sent_cnt = 0;
  int   gap = 0;

  triangle_circumcenter_3d #(.FRAC_BITS(FracBits)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic wide_t det3(input wide_t m [0:8]);
    wide_t t0, t1, t2;
    t0 = m[4] * m[8] - m[5] * m[7];
    t1 = m[3] * m[8] - m[5] * m[6];
    t2 = m[3] * m[7] - m[4] * m[6];
    return m[0] * t0 - m[1] * t1 + m[2] * t2;
  endfunction

  function automatic logic [OutW-1:0] scaled_quotient(input wide_t num, input wide_t den,
                                                     inout logic sat);
    logic  neg;
    wide_t mag, q;
    neg = num[255];
    mag = neg ? -num : num;
    mag = mag <<< FracBits;
    q = wide_t'($unsigned(mag) / $unsigned(den));
    if (!neg) begin
      if (q > 64'h7FFF_FFFF) begin
        sat = 1;
        return PosMax;
      end
      return q[OutW-1:0];
    end
    if (q > 64'h8000_0000) begin
      sat = 1;
      return NegMin;
    end
    return -q[OutW-1:0];
  endfunction

  function automatic out_t circumcenter(input in_t t);
    wide_t a [0:2], b [0:2], c [0:2], r0 [0:2], r1 [0:2], n [0:2], rhs [0:2];
    wide_t m [0:8], tmp [0:8];
    wide_t det;
    logic  sat;
    out_t  res;
    a[0] = t.ax;    a[1] = t.ay;       a[2] = t.az;
    b[0] = t.bx;    b[1] = t.by_coord; b[2] = t.bz;
    c[0] = t.cx_in; c[1] = t.cy_in;    c[2] = t.cz_in;
    for (int i = 0; i < 3; i++) begin
      r0[i] = c[i] - a[i];
      r1[i] = b[i] - a[i];
    end
    n[0] = r0[1] * r1[2] - r1[1] * r0[2];
    n[1] = r1[0] * r0[2] - r0[0] * r1[2];
    n[2] = r0[0] * r1[1] - r1[0] * r0[1];
    for (int i = 0; i < 3; i++) begin
      m[i] = r0[i];
      m[3+i] = r1[i];
      m[6+i] = n[i];
    end
    rhs[0] = 0; rhs[1] = 0; rhs[2] = 0;
    for (int i = 0; i < 3; i++) begin
      rhs[0] += r0[i] * (a[i] + c[i]);
      rhs[1] += r1[i] * (a[i] + b[i]);
      rhs[2] += n[i] * (2 * a[i]);
    end
    res = '0;
    det = det3(m);
    if (det == 0) begin
      res.singular = 1;
      return res;
    end
    sat = 0;
    tmp = m;
    for (int i = 0; i < 3; i++) tmp[3*i] = rhs[i];
    res.center_x = scaled_quotient(det3(tmp), 2 * det, sat);
    tmp = m;
    for (int i = 0; i < 3; i++) tmp[3*i+1] = rhs[i];
    res.center_y = scaled_quotient(det3(tmp), 2 * det, sat);
    tmp = m;
    for (int i = 0; i < 3; i++) tmp[3*i+2] = rhs[i];
    res.center_z = scaled_quotient(det3(tmp), 2 * det, sat);
    res.saturated = sat;
    return res;
  endfunction

  function automatic int pick_gap();
    if (((sent_cnt / 200) % 3) == 1) return 0;
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [CoordW-1:0] rand_coord(input int mode);
    case (mode)
      0: return CoordW'($urandom());
      1: return CoordW'($urandom_range(0, 40) - 20);
      default: return CoordW'(($urandom_range(0, 1) ? 32'h7FFF : 32'h8000) ^
                              $urandom_range(0, 3));
    endcase
  endfunction

  function automatic in_t rand_tri();
    in_t t;
    int  mode, k;
    mode = $urandom_range(0, 9);
    if (mode < 5) mode = 0;
    else if (mode < 8) mode = 1;
    else mode = 2;
    t.ax = rand_coord(mode); t.ay = rand_coord(mode); t.az = rand_coord(mode);
    t.bx = rand_coord(mode); t.by_coord = rand_coord(mode); t.bz = rand_coord(mode);
    t.cx_in = rand_coord(mode); t.cy_in = rand_coord(mode); t.cz_in = rand_coord(mode);
    if ($urandom_range(0, 9) == 0) begin
      // nearly or exactly collinear
      t.ax = CoordW'($urandom_range(0, 2000) - 1000);
      t.ay = CoordW'($urandom_range(0, 2000) - 1000);
      t.az = CoordW'($urandom_range(0, 2000) - 1000);
      t.bx = CoordW'(t.ax + $urandom_range(0, 200) - 100);
      t.by_coord = CoordW'(t.ay + $urandom_range(0, 200) - 100);
      t.bz = CoordW'(t.az + $urandom_range(0, 200) - 100);
      k = $urandom_range(0, 20) - 10;
      t.cx_in = CoordW'(t.ax + k * (t.bx - t.ax) + $urandom_range(0, 1));
      t.cy_in = CoordW'(t.ay + k * (t.by_coord - t.ay));
      t.cz_in = CoordW'(t.az + k * (t.bz - t.az) + $urandom_range(0, 1));
    end
    return t;
  endfunction

  function automatic in_t make_tri(input int a0, a1, a2, b0, b1, b2, c0, c1, c2);
    in_t t;
    t.ax = CoordW'(a0); t.ay = CoordW'(a1); t.az = CoordW'(a2);
    t.bx = CoordW'(b0); t.by_coord = CoordW'(b1); t.bz = CoordW'(b2);
    t.cx_in = CoordW'(c0); t.cy_in = CoordW'(c1); t.cz_in = CoordW'(c2);
    return t;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_centers.push_back(circumcenter(in_data));
        sent_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 0;
        end else if ((sent_cnt == 20 || sent_cnt == 700) && expected_centers.size() > 0) begin
          in_valid <= 0;
        end else if (pending_tris.size() > 0) begin
          in_valid <= 1;
          in_data <= pending_tris.pop_front();
          gap = pick_gap();
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_centers.size() == 0) begin
          $error("unexpected result word");
          errors++;
        end else begin
          out_t exp_w;
          exp_w = expected_centers.pop_front();
          if (out_data.center_x !== exp_w.center_x) begin
            $error("center_x expected %0d actual %0d", exp_w.center_x, out_data.center_x);
            errors++;
          end
          if (out_data.center_y !== exp_w.center_y) begin
            $error("center_y expected %0d actual %0d", exp_w.center_y, out_data.center_y);
            errors++;
          end
          if (out_data.center_z !== exp_w.center_z) begin
            $error("center_z expected %0d actual %0d", exp_w.center_z, out_data.center_z);
            errors++;
          end
          if (out_data.singular !== exp_w.singular) begin
            $error("singular expected %0b actual %0b", exp_w.singular, out_data.singular);
            errors++;
          end
          if (out_data.saturated !== exp_w.saturated) begin
            $error("saturated expected %0b actual %0b", exp_w.saturated, out_data.saturated);
            errors++;
          end
        end
      end
      if (((sent_cnt / 200) % 3) == 1) out_stall <= 0;
      else if ($urandom_range(0, 99) < 3) out_stall <= 1;
      else if ($urandom_range(0, 9) < 3) out_stall <= ($urandom_range(0, 9) < 3);
      else out_stall <= out_stall && ($urandom_range(0, 9) < 8);
    end
  end

  initial begin
    rst_n = 0;
    // directed: extremes, degenerate and saturating cases
    pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_tris.push_back(make_tri(32767, 32767, 32767, 32767, 32767, 32767,
                                    32767, 32767, 32767));
    pending_tris.push_back(make_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                                    -32768, -32768, -32768));
    pending_tris.push_back(make_tri(0, 0, 0, 4, 0, 0, 0, 4, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 0, 1));
    pending_tris.push_back(make_tri(-32768, 0, 0, 32767, 0, 0, 0, 32767, 0));
    pending_tris.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                                    0, 32767, -32768));
    pending_tris.push_back(make_tri(1, 2, 3, 2, 4, 6, 3, 6, 9));
    pending_tris.push_back(make_tri(5, 5, 5, 5, 5, 5, 9, 1, 0));
    pending_tris.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                                    32767, 32767, 32766));
    pending_tris.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                                    32766, 32767, 32767));
    pending_tris.push_back(make_tri(0, 0, 0, 32767, 32767, 32767, 1, 1, 2));
    pending_tris.push_back(make_tri(32767, -32768, 32767, -32768, 32767, -32768,
                                    32767, 32767, 32767));
    pending_tris.push_back(make_tri(-3, -7, 2, 11, -5, 0, 4, 9, -13));
    pending_tris.push_back(make_tri(0, 0, 0, -1, 0, 0, 0, -1, 0));
    pending_tris.push_back(make_tri(100, 100, 100, 101, 100, 100, 100, 101, 100));
    for (int i = pending_tris.size(); i < NumItems; i++) pending_tris.push_back(rand_tri());
    repeat (2) @(posedge clk);
    rst_n <= 1;
    wait (pending_tris.size() == 0 && sent_cnt == NumItems && expected_centers.size() == 0);
    repeat (100) @(posedge clk);
    if (expected_centers.size() != 0) errors++;
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* triangle_circumcenter_3d.f */
+incdir+hdl
hdl/tcc_pkg.sv
hdl/tcc_mul.sv
hdl/tcc_front.sv
hdl/tcc_div_lane.sv
hdl/triangle_circumcenter_3d.sv
verif/triangle_circumcenter_3d_tb.sv
